// ----- rtl/afd_pkg.sv -----
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types and constants of the sync/length/type/checksum frame parser.
// ----------------------------------------------------------------------------
package afd_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h7E;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    localparam int BYTE_W   = 8;
    localparam int LENGTH_W = 16;
    localparam int POS_W    = LENGTH_W + 1;
    localparam int STATUS_W = 3;

    localparam int S_TDATA_W = BYTE_W;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 2 * BYTE_W + 2 * LENGTH_W;
    localparam int M_TUSER_W = STATUS_W + 1;

    typedef enum logic [STATUS_W-1:0] {
        ST_BUSY     = 3'd0,
        ST_DONE     = 3'd1,
        ST_CHECKSUM = 3'd2,
        ST_LENGTH   = 3'd3,
        ST_LINE     = 3'd4
    } status_t;

    typedef struct packed {
        logic              line_error;
        logic [BYTE_W-1:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic                data_valid;
        status_t             status;
        logic [LENGTH_W-1:0] data_index;
        logic [BYTE_W-1:0]   data_byte;
        logic [LENGTH_W-1:0] frame_length;
        logic [BYTE_W-1:0]   frame_type;
    } result_t;

endpackage

// ----- rtl/afd_parser.sv -----
// ----------------------------------------------------------------------------
// afd_parser
// Frame parse state and the per-byte update that forms one result word.
// ----------------------------------------------------------------------------
module afd_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  afd_pkg::in_word_t in_word,
    output afd_pkg::result_t  result
);
    import afd_pkg::*;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [LENGTH_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0]   type_reg, type_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;
    logic [POS_W-1:0]    last_pos;
    logic [POS_W-1:0]    payload_pos;
    logic [BYTE_W-1:0]   check_sum;

    assign last_pos    = {1'b0, length_reg} + POS_W'(3);
    assign payload_pos = pos_reg - POS_W'(4);
    assign check_sum   = sum_reg + in_word.rx_byte + BYTE_W'(1);

    always_comb
    begin
        pos_next    = pos_reg;
        length_next = length_reg;
        type_next   = type_reg;
        sum_next    = sum_reg;
        result      = '0;
        result.status = ST_BUSY;

        if (in_word.line_error)
        begin
            result.status = ST_LINE;
            pos_next      = '0;
        end
        else
        begin
            case (pos_reg)
                POS_W'(0):
                begin
                    if (in_word.rx_byte == SYNC_BYTE)
                    begin
                        pos_next = POS_W'(1);
                    end
                end
                POS_W'(1):
                begin
                    length_next = {in_word.rx_byte, 8'h00};
                    pos_next    = POS_W'(2);
                end
                POS_W'(2):
                begin
                    length_next = {length_reg[LENGTH_W-1:BYTE_W], in_word.rx_byte};
                    if ({length_reg[LENGTH_W-1:BYTE_W], in_word.rx_byte} == '0)
                    begin
                        result.status = ST_LENGTH;
                        pos_next      = '0;
                    end
                    else
                    begin
                        pos_next = POS_W'(3);
                    end
                end
                POS_W'(3):
                begin
                    type_next = in_word.rx_byte;
                    sum_next  = in_word.rx_byte;
                    pos_next  = POS_W'(4);
                end
                default:
                begin
                    if (pos_reg > last_pos)
                    begin
                        result.status = ST_LENGTH;
                        pos_next      = '0;
                    end
                    else if (pos_reg < last_pos)
                    begin
                        result.data_byte  = in_word.rx_byte;
                        result.data_index = payload_pos[LENGTH_W-1:0];
                        result.data_valid = 1'b1;
                        sum_next          = sum_reg + in_word.rx_byte;
                        pos_next          = pos_reg + POS_W'(1);
                    end
                    else
                    begin
                        result.status = (check_sum != '0) ? ST_CHECKSUM : ST_DONE;
                        pos_next      = '0;
                    end
                end
            endcase
        end

        result.frame_type   = type_next;
        result.frame_length = length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            length_reg <= '0;
            type_reg   <= '0;
            sum_reg    <= '0;
        end
        else if (advance)
        begin
            pos_reg    <= pos_next;
            length_reg <= length_next;
            type_reg   <= type_next;
            sum_reg    <= sum_next;
        end
    end

endmodule

// ----- rtl/afd_out_stage.sv -----
// ----------------------------------------------------------------------------
// afd_out_stage
// Result register with handshake toward the master-side stream.
// ----------------------------------------------------------------------------
module afd_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  afd_pkg::result_t result,
    output logic             ready,
    output logic             valid,
    input  logic             taken,
    output afd_pkg::result_t word
);
    import afd_pkg::*;

    logic    valid_reg;
    result_t word_reg;

    assign ready = !valid_reg || taken;
    assign valid = valid_reg;
    assign word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            word_reg <= result;
        end
    end

endmodule

// ----- rtl/api_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// api_frame_deframer
// Serial frame parser: sync 0x7E, 16-bit big-endian length, type byte,
// length-1 payload bytes and a checksum byte.
//
// Input stream s_axis: one received byte per word in tdata, the receiver's
// line-error flag in tuser. Output stream m_axis: one result word for every
// input word, carrying status, the current frame type and length, and the
// payload byte with its index when tuser marks it valid.
// Path: the accepted word is held in the input register; its result is then
// registered in the result register for m_axis. Throughput: 1 word per cycle
// unless m_axis stalls; the parse step is one pass of logic between the registers.
// Reset: parser returns to hunting for sync, length and type read zero, both
// registers empty.
// Stall: when m_axis_tready is low the result register holds its word, the
// input register fills behind it, and s_axis_tready drops once both are full.
// Status codes: 0 in progress, 1 frame complete, 2 checksum error,
// 3 length error, 4 line error.
// ----------------------------------------------------------------------------
module api_frame_deframer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [afd_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // rx_byte
    input  logic [afd_pkg::S_TUSER_W-1:0]  s_axis_tuser,  // line_error
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // frame_type, frame_length, data_byte, data_index
    output logic [afd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic [afd_pkg::M_TUSER_W-1:0]  m_axis_tuser   // status, data_valid
);
    import afd_pkg::*;

    logic     in_valid_reg;
    in_word_t in_word_reg;
    logic     out_ready;
    logic     advance;
    result_t  result;
    result_t  out_word;

    assign advance       = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_word_reg.rx_byte    <= s_axis_tdata;
            in_word_reg.line_error <= s_axis_tuser[0];
        end
    end

    afd_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_word (in_word_reg),
        .result  (result)
    );

    afd_out_stage u_out_stage
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (in_valid_reg),
        .result (result),
        .ready  (out_ready),
        .valid  (m_axis_tvalid),
        .taken  (m_axis_tready),
        .word   (out_word)
    );

    assign m_axis_tdata = {out_word.data_index, out_word.data_byte,
                           out_word.frame_length, out_word.frame_type};
    assign m_axis_tuser = {out_word.data_valid, out_word.status};

endmodule
